// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/sha1md_pkg.sv =====
package sha1md_pkg;

	// Initial chaining values H0 to H4.
	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] PAD_WORD   = 32'h80000000;
	localparam logic [6:0]  ROUND_LAST = 7'd79;
	localparam logic [3:0]  LEN_SLOT   = 4'd14;
	localparam logic [3:0]  FILL_LAST  = 4'd15;
	localparam logic [2:0]  FULL_BYTES = 3'd4;
	localparam logic [2:0]  DIG_LAST   = 3'd4;

	// Source of the word pushed into the message schedule.
	typedef enum logic [2:0] {
		SRC_DATA   = 3'd0,
		SRC_MASK   = 3'd1,
		SRC_PAD    = 3'd2,
		SRC_ZERO   = 3'd3,
		SRC_LEN_HI = 3'd4,
		SRC_LEN_LO = 3'd5
	} word_src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        push;
		word_src_t   src;
		logic [2:0]  nbytes;
		logic        count_en;
		logic        count_clear;
		logic        load_vars;
		logic        round;
		logic [1:0]  grp;
		logic        fold;
		logic        chain_init;
		logic [2:0]  out_idx;
	} dp_cmd_t;

	// Round constant for each group of twenty rounds.
	function automatic logic [31:0] round_k(input logic [1:0] grp);
		logic [31:0] k;
		case (grp)
			2'd0: k = 32'h5A827999;
			2'd1: k = 32'h6ED9EBA1;
			2'd2: k = 32'h8F1BBCDC;
			default: k = 32'hCA62C1D6;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/sha1md_ctrl.sv =====
module sha1md_ctrl import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	input  logic [2:0]  valid_bytes,
	input  logic        end_of_message,
	output logic        msg_stall,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [2:0]  word_index,
	output logic        last_word,
	output dp_cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	localparam logic [6:0] GRP1_START = 7'd20;
	localparam logic [6:0] GRP2_START = 7'd40;
	localparam logic [6:0] GRP3_START = 7'd60;

	state_t      state_q, state_d;
	logic [3:0]  fill_q, fill_d;
	logic [6:0]  round_q, round_d;
	logic [2:0]  idx_q, idx_d;
	logic        pad_q, pad_d;
	logic        final_q, final_d;
	logic        lenhi_q, lenhi_d;
	logic [2:0]  nb;

	// Byte counts above four are treated as a full word.
	assign nb = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;

	assign msg_stall  = (state_q != ST_IDLE);
	assign dig_valid  = (state_q == ST_EMIT);
	assign word_index = idx_q;
	assign last_word  = (idx_q == DIG_LAST);

	// Next-state and command decode.
	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		round_d = round_q;
		idx_d   = idx_q;
		pad_d   = pad_q;
		final_d = final_q;
		lenhi_d = lenhi_q;
		cmd     = '0;
		cmd.src = SRC_ZERO;
		cmd.out_idx = idx_q;
		if (round_q < GRP1_START) begin
			cmd.grp = 2'd0;
		end else if (round_q < GRP2_START) begin
			cmd.grp = 2'd1;
		end else if (round_q < GRP3_START) begin
			cmd.grp = 2'd2;
		end else begin
			cmd.grp = 2'd3;
		end
		case (state_q)
			ST_IDLE: begin
				if (msg_valid) begin
					cmd.push     = 1'b1;
					cmd.count_en = 1'b1;
					fill_d       = fill_q + 4'd1;
					if (!end_of_message) begin
						cmd.src    = SRC_DATA;
						cmd.nbytes = FULL_BYTES;
					end else begin
						cmd.nbytes = nb;
						cmd.src    = (nb == FULL_BYTES) ? SRC_DATA : SRC_MASK;
						pad_d      = (nb == FULL_BYTES);
						final_d    = 1'b1;
						state_d    = ST_PAD;
					end
					if (fill_q == FILL_LAST) begin
						cmd.load_vars = 1'b1;
						round_d       = '0;
						state_d       = ST_ROUND;
					end
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				fill_d   = fill_q + 4'd1;
				if (pad_q) begin
					cmd.src = SRC_PAD;
					pad_d   = 1'b0;
				end else if (fill_q == LEN_SLOT) begin
					cmd.src = SRC_LEN_HI;
					lenhi_d = 1'b1;
				end else if (fill_q == FILL_LAST && lenhi_q) begin
					cmd.src = SRC_LEN_LO;
				end else begin
					cmd.src = SRC_ZERO;
				end
				if (fill_q == FILL_LAST) begin
					cmd.load_vars = 1'b1;
					round_d       = '0;
					state_d       = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (round_q == ROUND_LAST) begin
					state_d = ST_FOLD;
				end else begin
					round_d = round_q + 7'd1;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				idx_d    = '0;
				if (lenhi_q) begin
					state_d = ST_EMIT;
				end else if (final_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!dig_stall) begin
					if (idx_q == DIG_LAST) begin
						cmd.chain_init  = 1'b1;
						cmd.count_clear = 1'b1;
						final_d         = 1'b0;
						lenhi_d         = 1'b0;
						state_d         = ST_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			round_q <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			final_q <= 1'b0;
			lenhi_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			round_q <= round_d;
			idx_q   <= idx_d;
			pad_q   <= pad_d;
			final_q <= final_d;
			lenhi_q <= lenhi_d;
		end
	end

endmodule

// ===== rtl/sha1md_datapath.sv =====
module sha1md_datapath import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [31:0] data_word,
	output logic [31:0] digest_word
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [5];
	logic [31:0] chain_q [5];
	logic [60:0] count_q;

	logic [31:0] keep_mask;
	logic [31:0] pad_bits;
	logic [31:0] push_word;
	logic [31:0] sched_x;
	logic [31:0] sched_new;
	logic [31:0] f_val;
	logic [31:0] t_val;

	// Final-word byte masking and in-word pad placement.
	always_comb begin
		case (cmd.nbytes)
			3'd0: begin
				keep_mask = 32'h00000000;
				pad_bits  = 32'h80000000;
			end
			3'd1: begin
				keep_mask = 32'hFF000000;
				pad_bits  = 32'h00800000;
			end
			3'd2: begin
				keep_mask = 32'hFFFF0000;
				pad_bits  = 32'h00008000;
			end
			3'd3: begin
				keep_mask = 32'hFFFFFF00;
				pad_bits  = 32'h00000080;
			end
			default: begin
				keep_mask = 32'hFFFFFFFF;
				pad_bits  = 32'h00000000;
			end
		endcase
	end

	// Word entering the schedule window.
	always_comb begin
		case (cmd.src)
			SRC_DATA:   push_word = data_word;
			SRC_MASK:   push_word = (data_word & keep_mask) | pad_bits;
			SRC_PAD:    push_word = PAD_WORD;
			SRC_LEN_HI: push_word = count_q[60:29];
			SRC_LEN_LO: push_word = {count_q[28:0], 3'b000};
			default:    push_word = '0;
		endcase
	end

	// Schedule expansion: the window holds W[t] to W[t+15].
	assign sched_x   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign sched_new = {sched_x[30:0], sched_x[31]};

	// Round function.
	always_comb begin
		case (cmd.grp)
			2'd0: f_val = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			2'd2: f_val = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			default: f_val = v_q[1] ^ v_q[2] ^ v_q[3];
		endcase
	end

	assign t_val = {v_q[0][26:0], v_q[0][31:27]} + f_val + v_q[4] + w_q[0] + round_k(cmd.grp);

	// Schedule window shifts on every push and every round.
	always_ff @(posedge clk) begin
		if (cmd.push || cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= cmd.push ? push_word : sched_new;
		end
	end

	// Working variables, chaining values and byte counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				v_q[i]     <= '0;
				chain_q[i] <= H_INIT[i];
			end
			count_q <= '0;
		end else begin
			if (cmd.load_vars) begin
				for (int i = 0; i < 5; i++) begin
					v_q[i] <= chain_q[i];
				end
			end else if (cmd.round) begin
				v_q[0] <= t_val;
				v_q[1] <= v_q[0];
				v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3];
			end
			if (cmd.chain_init) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= H_INIT[i];
				end
			end else if (cmd.fold) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
			if (cmd.count_clear) begin
				count_q <= '0;
			end else if (cmd.count_en) begin
				count_q <= count_q + {58'd0, cmd.nbytes};
			end
		end
	end

	// Digest word selection.
	always_comb begin
		case (cmd.out_idx)
			3'd0: digest_word = chain_q[0];
			3'd1: digest_word = chain_q[1];
			3'd2: digest_word = chain_q[2];
			3'd3: digest_word = chain_q[3];
			3'd4: digest_word = chain_q[4];
			default: digest_word = '0;
		endcase
	end

endmodule

// ===== rtl/sha1_message_digest.sv =====
// Non-final word: taken while idle; a word that fills a 16-word block then starts 80 rounds and a fold.
// Final word: padding words go in one per cycle, then one or two compressions,
// then five digest beats, one per cycle when not stalled.
// Message words are not taken while a block is compressed; throughput is set by the single shared round unit.
// Reset restores the initial chaining values and clears the counters; there is no clearing pass.
module sha1_message_digest import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        end_of_message,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	dp_cmd_t cmd;

	// Sequencer for loading, padding, rounds and digest output.
	sha1md_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.valid_bytes    (valid_bytes),
		.end_of_message (end_of_message),
		.msg_stall      (msg_stall),
		.dig_valid      (dig_valid),
		.dig_stall      (dig_stall),
		.word_index     (word_index),
		.last_word      (last_word),
		.cmd            (cmd)
	);

	// Schedule window, round unit, chaining values and length counter.
	sha1md_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_word   (data_word),
		.digest_word (digest_word)
	);

endmodule

// ===== rtl/sha1md_checker.sv =====
`include "assert_macros.svh"

module sha1md_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_stall,
	input logic        dig_valid,
	input logic        dig_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// A stalled digest beat holds its payload.
	`ASSERT_NEXT(a_dig_hold, clk, arst_n, dig_valid && dig_stall,
		dig_valid && $stable(digest_word) && $stable(word_index))

	// No message beat is taken while the digest is being delivered.
	`ASSERT_IMPLY(a_no_input_in_emit, clk, arst_n, dig_valid, msg_stall)

	// Digest beats advance through the index in order.
	`ASSERT_NEXT(a_index_step, clk, arst_n, dig_valid && !dig_stall && !last_word,
		dig_valid && word_index == $past(word_index) + 3'd1)

	// The last flag marks exactly the fifth digest word.
	`ASSERT_IMPLY(a_last_flag, clk, arst_n, dig_valid, last_word == (word_index == 3'd4))

	// After the fifth word the block returns to accepting message beats.
	`ASSERT_NEXT(a_back_to_idle, clk, arst_n, dig_valid && !dig_stall && last_word,
		!dig_valid && !msg_stall)

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (.*);
